>>> src/smm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and types for the small matrix multiplier.
// Used by the channel interfaces, the cell, the load sequencer and the top level.
package smm_pkg;

	// Matrix size (square, MATRIX_DIM x MATRIX_DIM)
	localparam int MATRIX_DIM = 3;

	// Bits needed to address one row or column inside the matrix
	localparam int IDX_W = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;

	// Fixed field widths of the channels
	localparam int ELEM_W = 8;
	localparam int MUL_W  = 2 * ELEM_W;
	localparam int PROD_W = 17;
	localparam int POS_W  = 2;

	// Last row / column index
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MATRIX_DIM - 1);

	// Element write broadcast from the sequencer to every cell
	typedef struct packed {
		logic                     we;
		logic                     to_b;
		logic [IDX_W-1:0]         sel;
		logic [IDX_W-1:0]         idx;
		logic signed [ELEM_W-1:0] data;
	} load_t;

	// Partial sum token handed from cell to cell
	typedef struct packed {
		logic                     valid;
		logic signed [PROD_W-1:0] sum;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic                     last;
	} token_t;

endpackage
`default_nettype wire

>>> src/smm_elem_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Input channel carrying one matrix element per beat.
// Depends on smm_pkg for the element width.
interface smm_elem_if;
	logic                              valid;
	logic                              ready;
	logic signed [smm_pkg::ELEM_W-1:0] element_value;

	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface
`default_nettype wire

>>> src/smm_prod_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Output channel carrying one product matrix entry per beat.
// Depends on smm_pkg for the field widths.
interface smm_prod_if;
	logic                              valid;
	logic                              ready;
	logic signed [smm_pkg::PROD_W-1:0] product_value;
	logic [smm_pkg::POS_W-1:0]         row_index;
	logic [smm_pkg::POS_W-1:0]         column_index;
	logic                              final_entry;

	modport source (output valid, output product_value, output row_index,
		output column_index, output final_entry, input ready);
	modport sink (input valid, input product_value, input row_index,
		input column_index, input final_entry, output ready);
endinterface
`default_nettype wire

>>> src/smm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One cell of the multiply chain: holds column k of A and row k of B,
// adds A[r][k]*B[k][c] to the passing partial sum. Depends on smm_pkg.
module smm_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [smm_pkg::IDX_W-1:0]    cell_index,
	input  wire smm_pkg::load_t               ld,
	input  wire logic                         adv,
	input  wire smm_pkg::token_t              tok_in,
	output smm_pkg::token_t                   tok_out
);

	logic signed [smm_pkg::ELEM_W-1:0] a_q [0:smm_pkg::MATRIX_DIM-1];
	logic signed [smm_pkg::ELEM_W-1:0] b_q [0:smm_pkg::MATRIX_DIM-1];
	logic signed [smm_pkg::MUL_W-1:0]  mul;
	logic signed [smm_pkg::PROD_W-1:0] sum_next;
	logic                              valid_q;
	logic signed [smm_pkg::PROD_W-1:0] sum_q;
	logic [smm_pkg::IDX_W-1:0]         row_q;
	logic [smm_pkg::IDX_W-1:0]         col_q;
	logic                              last_q;

	// Capture elements addressed to this cell
	always_ff @(posedge clk) begin
		if (ld.we && ld.sel == cell_index) begin
			if (ld.to_b) begin
				b_q[ld.idx] <= ld.data;
			end else begin
				a_q[ld.idx] <= ld.data;
			end
		end
	end

	// Multiply this cell's pair and accumulate
	assign mul      = a_q[tok_in.row] * b_q[tok_in.col];
	assign sum_next = tok_in.sum + smm_pkg::PROD_W'(mul);

	// Hand the token on to the neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_q  <= sum_next;
			row_q  <= tok_in.row;
			col_q  <= tok_in.col;
			last_q <= tok_in.last;
		end
	end

	always_comb begin
		tok_out.valid = valid_q;
		tok_out.sum   = sum_q;
		tok_out.row   = row_q;
		tok_out.col   = col_q;
		tok_out.last  = last_q;
	end

endmodule
`default_nettype wire

>>> src/smm_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// Load and issue sequencer: steers elements to the cells and, once both matrices
// are in, issues one entry token per cycle while adv is high. Depends on smm_pkg.
module smm_seq (
	input  wire logic      clk,
	input  wire logic      arst_n,
	smm_elem_if.sink       elem,
	input  wire logic      adv,
	input  wire logic      busy,
	output smm_pkg::load_t ld,
	output smm_pkg::token_t tok
);

	logic                      half_q;
	logic [smm_pkg::IDX_W-1:0] ld_row_q;
	logic [smm_pkg::IDX_W-1:0] ld_col_q;
	logic                      emit_q;
	logic [smm_pkg::IDX_W-1:0] em_row_q;
	logic [smm_pkg::IDX_W-1:0] em_col_q;
	logic                      accept;
	logic                      em_last;

	// Hold off new elements until the chain has drained
	assign elem.ready = !emit_q && !busy;
	assign accept     = elem.valid && elem.ready;

	// Route element: A[r][k] goes to cell k slot r, B[k][c] to cell k slot c
	always_comb begin
		ld.we   = accept;
		ld.to_b = half_q;
		ld.sel  = half_q ? ld_row_q : ld_col_q;
		ld.idx  = half_q ? ld_col_q : ld_row_q;
		ld.data = elem.element_value;
	end

	assign em_last = (em_row_q == smm_pkg::IDX_LAST) && (em_col_q == smm_pkg::IDX_LAST);

	always_comb begin
		tok.valid = emit_q;
		tok.sum   = '0;
		tok.row   = em_row_q;
		tok.col   = em_col_q;
		tok.last  = em_last;
	end

	// Advance load position and issue position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= 1'b0;
			ld_row_q <= '0;
			ld_col_q <= '0;
			emit_q   <= 1'b0;
			em_row_q <= '0;
			em_col_q <= '0;
		end else begin
			if (accept) begin
				if (ld_col_q == smm_pkg::IDX_LAST) begin
					ld_col_q <= '0;
					if (ld_row_q == smm_pkg::IDX_LAST) begin
						ld_row_q <= '0;
						half_q   <= !half_q;
						if (half_q) begin
							emit_q   <= 1'b1;
							em_row_q <= '0;
							em_col_q <= '0;
						end
					end else begin
						ld_row_q <= ld_row_q + smm_pkg::IDX_W'(1);
					end
				end else begin
					ld_col_q <= ld_col_q + smm_pkg::IDX_W'(1);
				end
			end
			if (emit_q && adv) begin
				if (em_col_q == smm_pkg::IDX_LAST) begin
					em_col_q <= '0;
					if (em_row_q == smm_pkg::IDX_LAST) begin
						em_row_q <= '0;
						emit_q   <= 1'b0;
					end else begin
						em_row_q <= em_row_q + smm_pkg::IDX_W'(1);
					end
				end else begin
					em_col_q <= em_col_q + smm_pkg::IDX_W'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> src/small_matrix_multiply.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming 3x3 signed matrix multiplier. Send 18 signed 8-bit elements, A then B, each
// row-major, one beat per cycle; the block then returns the 9 entries of A*B in row-major
// order with their row and column and a final flag on the last. Entries run through a chain
// of 3 cells, one multiply-add per cell. The first entry leaves once its token, issued by
// the sequencer after the last element of B is taken, has been registered by each cell in
// turn; the rest follow one per cycle unless the sink stalls. Input ready stays low from
// the last element of B until the last entry has been taken.
// Depends on smm_pkg, smm_elem_if, smm_prod_if, smm_seq and smm_cell.
module small_matrix_multiply (
	input  wire logic  clk,
	input  wire logic  arst_n,
	smm_elem_if.sink   elem,
	smm_prod_if.source prod
);

	smm_pkg::load_t                   ld;
	smm_pkg::token_t                  chain [0:smm_pkg::MATRIX_DIM];
	logic [smm_pkg::MATRIX_DIM-1:0]   cell_valid;
	logic                             adv;
	logic                             busy;

	// Stall the whole chain while the output beat waits
	assign adv  = !prod.valid || prod.ready;
	assign busy = |cell_valid;

	smm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem),
		.adv    (adv),
		.busy   (busy),
		.ld     (ld),
		.tok    (chain[0])
	);

	// Row of multiply-add cells
	for (genvar k = 0; k < smm_pkg::MATRIX_DIM; k++) begin : g_cell
		smm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (smm_pkg::IDX_W'(k)),
			.ld         (ld),
			.adv        (adv),
			.tok_in     (chain[k]),
			.tok_out    (chain[k+1])
		);
		assign cell_valid[k] = chain[k+1].valid;
	end

	// Last cell register is the output register
	assign prod.valid         = chain[smm_pkg::MATRIX_DIM].valid;
	assign prod.product_value = chain[smm_pkg::MATRIX_DIM].sum;
	assign prod.row_index     = smm_pkg::POS_W'(chain[smm_pkg::MATRIX_DIM].row);
	assign prod.column_index  = smm_pkg::POS_W'(chain[smm_pkg::MATRIX_DIM].col);
	assign prod.final_entry   = chain[smm_pkg::MATRIX_DIM].last;

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for small_matrix_multiply: streams pairs of 3x3 matrices, predicts A*B.
// Depends on smm_pkg, smm_elem_if, smm_prod_if and the small_matrix_multiply top level.
module tb;

	localparam int CELLS          = smm_pkg::MATRIX_DIM * smm_pkg::MATRIX_DIM;
	localparam int ELEMS_PER_PAIR = 2 * CELLS;
	localparam int RANDOM_PAIRS   = 9;
	localparam int CALM_PAIRS     = 2;
	localparam int HOLD_OFF_PAIR  = 1;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 20;
	localparam int REPORT_LIMIT   = 10;

	// One entry of the product matrix as seen on the output channel
	typedef struct {
		logic signed [smm_pkg::PROD_W-1:0] value;
		logic [smm_pkg::POS_W-1:0]         row;
		logic [smm_pkg::POS_W-1:0]         col;
		logic                              last;
	} entry_t;

	// Extremes of the product range: row of -128 against column of -128, and -128 against 127
	localparam logic signed [smm_pkg::ELEM_W-1:0] CORNER_PAIR [ELEMS_PER_PAIR] = '{
		-128, -128, -128,  127,  127,  127,    0,    1,   -1,
		-128,  127,   -1, -128,  127,    0, -128,  127,    1
	};

	// Track the matrix load and hold the product entries still owed by the block
	class product_scoreboard;
		logic signed [smm_pkg::ELEM_W-1:0] left_store [CELLS];
		logic signed [smm_pkg::ELEM_W-1:0] right_store [CELLS];
		int unsigned                       load_pos;
		entry_t                            owed_entries [$];
		int unsigned                       mismatch_count;

		function new();
			load_pos = 0;
			mismatch_count = 0;
		endfunction

		function void note_element(logic signed [smm_pkg::ELEM_W-1:0] elem);
			int acc;
			entry_t ent;
			if (load_pos < CELLS) begin
				left_store[load_pos] = elem;
			end else begin
				right_store[load_pos - CELLS] = elem;
			end
			if (load_pos + 1 < ELEMS_PER_PAIR) begin
				load_pos++;
				return;
			end
			// Last element of B: owe the whole product, row-major
			load_pos = 0;
			for (int r = 0; r < smm_pkg::MATRIX_DIM; r++) begin
				for (int c = 0; c < smm_pkg::MATRIX_DIM; c++) begin
					acc = 0;
					for (int k = 0; k < smm_pkg::MATRIX_DIM; k++) begin
						acc += int'(left_store[r * smm_pkg::MATRIX_DIM + k]) *
							int'(right_store[k * smm_pkg::MATRIX_DIM + c]);
					end
					ent.value = acc[smm_pkg::PROD_W-1:0];
					ent.row = smm_pkg::POS_W'(r);
					ent.col = smm_pkg::POS_W'(c);
					ent.last = (r == smm_pkg::MATRIX_DIM - 1) &&
						(c == smm_pkg::MATRIX_DIM - 1);
					owed_entries.push_back(ent);
				end
			end
		endfunction

		function void check_entry(entry_t got);
			entry_t want;
			if (owed_entries.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: unexpected entry value %0d row %0d col %0d final %0b",
						$realtime, got.value, got.row, got.col, got.last);
				return;
			end
			want = owed_entries.pop_front();
			if (got.value !== want.value || got.row !== want.row ||
					got.col !== want.col || got.last !== want.last) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: mismatch: want %0d r%0d c%0d f%0b, got %0d r%0d c%0d f%0b",
						$realtime, want.value, want.row, want.col, want.last,
						got.value, got.row, got.col, got.last);
			end
		endfunction

		function int pending();
			return owed_entries.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   sender_idle_odds;
	int   receiver_idle_odds;
	bit   hold_off_request;
	int   quiet_cycles;
	product_scoreboard product_sb;

	smm_elem_if elem_ch ();
	smm_prod_if prod_ch ();

	small_matrix_multiply u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem_ch),
		.prod   (prod_ch)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Feed every accepted element beat to the predictor
	always @(posedge clk) begin
		if (arst_n && elem_ch.valid && elem_ch.ready)
			product_sb.note_element(elem_ch.element_value);
	end

	// Check every accepted product beat against the oldest owed entry
	always @(posedge clk) begin
		entry_t got;
		if (arst_n && prod_ch.valid && prod_ch.ready) begin
			got.value = prod_ch.product_value;
			got.row = prod_ch.row_index;
			got.col = prod_ch.column_index;
			got.last = prod_ch.final_entry;
			product_sb.check_entry(got);
		end
	end

	// Pick how often one side idles during a pair, none at all being one choice
	function automatic int pick_idle_odds();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 3;
			2: return 6;
			default: return 12;
		endcase
	endfunction

	// Mix full-range values with extremes and small values
	function automatic logic signed [smm_pkg::ELEM_W-1:0] random_element();
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 3))
					0: return -128;
					1: return 127;
					2: return -1;
					default: return 0;
				endcase
			end
			1: return smm_pkg::ELEM_W'($urandom_range(0, 9)) - smm_pkg::ELEM_W'(5);
			default: return smm_pkg::ELEM_W'($urandom);
		endcase
	endfunction

	// Offer one element beat, with an optional idle burst first, and hold until taken
	task automatic send_element(input logic signed [smm_pkg::ELEM_W-1:0] elem);
		if (sender_idle_odds != 0 && $urandom_range(1, sender_idle_odds) == 1) begin
			elem_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		elem_ch.valid <= 1'b1;
		elem_ch.element_value <= elem;
		do
			@(posedge clk);
		while (!(elem_ch.valid && elem_ch.ready));
	endtask

	// Drive output ready: random stall bursts, plus one long hold-off on request
	initial begin
		prod_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				prod_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				prod_ch.ready <= 1'b1;
			end else if (receiver_idle_odds != 0 &&
					$urandom_range(1, receiver_idle_odds) == 1) begin
				prod_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				prod_ch.ready <= 1'b1;
			end else begin
				prod_ch.ready <= 1'b1;
			end
		end
	end

	// End the run when nothing moves on either channel for too long
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((elem_ch.valid && elem_ch.ready) ||
					(prod_ch.valid && prod_ch.ready)))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Main sequence: reset, corner pair, random pairs, drain
	initial begin
		product_sb = new();
		arst_n = 1'b0;
		elem_ch.valid = 1'b0;
		elem_ch.element_value = '0;
		sender_idle_odds = 0;
		receiver_idle_odds = 0;
		hold_off_request = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner pair with both sides flowing freely
		for (int i = 0; i < ELEMS_PER_PAIR; i++)
			send_element(CORNER_PAIR[i]);

		// Random pairs: one long output hold-off, idling varied, calm at the end
		for (int p = 0; p < RANDOM_PAIRS; p++) begin
			if (p == HOLD_OFF_PAIR) begin
				sender_idle_odds = 0;
				receiver_idle_odds = 0;
				hold_off_request = 1'b1;
			end else if (p >= RANDOM_PAIRS - CALM_PAIRS) begin
				sender_idle_odds = 0;
				receiver_idle_odds = 0;
			end else begin
				sender_idle_odds = pick_idle_odds();
				receiver_idle_odds = pick_idle_odds();
			end
			for (int i = 0; i < ELEMS_PER_PAIR; i++)
				send_element(random_element());
		end
		elem_ch.valid <= 1'b0;

		// Drain owed entries, then allow for stray beats
		while (product_sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (product_sb.mismatch_count == 0 && product_sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
src/smm_pkg.sv
src/smm_elem_if.sv
src/smm_prod_if.sv
src/smm_cell.sv
src/smm_seq.sv
src/small_matrix_multiply.sv
sim/tb.sv
